@@ design/grid_to_triangle_list_macros.svh @@
// Assertion macros for the grid-to-triangle-list block.
// Used by grid_to_triangle_list.sv; expects i_clk and i_rst_n in scope.
`ifndef GRID_TO_TRIANGLE_LIST_MACROS_SVH
`define GRID_TO_TRIANGLE_LIST_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define G2T_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define G2T_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define G2T_ASSERT_NOW(label, ante, cons)
`define G2T_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/g2t_pkg.sv @@
// Shared constants and types for the grid-to-triangle-list block.
// No dependencies.
`default_nettype none

package g2t_pkg;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_PLANE_COUNT = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_idx;

    localparam logic [10:0] GRID_WIDTH_RST  = 11'd2;
    localparam logic [15:0] GRID_HEIGHT_RST = 16'd2;
    localparam logic [1:0]  PLANE_COUNT_RST = 2'd3;
    localparam logic [1:0]  PLANES_THREE    = 2'd3;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

endpackage

`default_nettype wire

@@ design/g2t_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// Read returns the old entry when read and write hit the same address.
`default_nettype none

module g2t_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ design/grid_to_triangle_list.sv @@
// Grid-to-triangle-list top level: line store, quad stage, output register.
// Depends on g2t_pkg, g2t_ram and grid_to_triangle_list_macros.svh.
//
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+-----------------------------------
//  vertex in | in  | i_in_valid / o_in_ready     | i_vertex_plane0..2
//  triangle  | out | o_out_valid / i_out_ready   | o_cornerK_planeP, o_last_of_pair
//  config    | in  | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// An interior vertex yields two triangles that leave the output register one per
// cycle while i_out_ready holds; a border vertex (row 0 or column 0) yields none.
// The line store is read and written in the accept cycle; its registered read data
// lands in the quad stage in the cycle after. Reset loads config defaults and clears
// counters, control and the left and upper-left vertices; the line store needs no
// clearing pass. Output stalls back up into the quad stage.
`default_nettype none

`include "grid_to_triangle_list_macros.svh"

module grid_to_triangle_list #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PLANE_BITS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // vertex input
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [PLANE_BITS-1:0]        i_vertex_plane0,
    input  wire logic [PLANE_BITS-1:0]        i_vertex_plane1,
    input  wire logic [PLANE_BITS-1:0]        i_vertex_plane2,
    // triangle output
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [PLANE_BITS-1:0]             o_corner0_plane0,
    output logic [PLANE_BITS-1:0]             o_corner0_plane1,
    output logic [PLANE_BITS-1:0]             o_corner0_plane2,
    output logic [PLANE_BITS-1:0]             o_corner1_plane0,
    output logic [PLANE_BITS-1:0]             o_corner1_plane1,
    output logic [PLANE_BITS-1:0]             o_corner1_plane2,
    output logic [PLANE_BITS-1:0]             o_corner2_plane0,
    output logic [PLANE_BITS-1:0]             o_corner2_plane1,
    output logic [PLANE_BITS-1:0]             o_corner2_plane2,
    output logic                              o_last_of_pair,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [g2t_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [g2t_pkg::PDATA_W-1:0]  pwdata,
    output logic      [g2t_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int WE  = (WB > 11) ? WB : 11;
    localparam int RAM_W = 3 * PLANE_BITS;

    typedef logic [PLANE_BITS-1:0] t_plane;
    typedef t_plane t_vtx [3];

    // ---------------- configuration registers ----------------
    logic [10:0] r_grid_width;
    logic [15:0] r_grid_height;
    logic [1:0]  r_plane_count;
    logic        cfg_wr;
    g2t_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = g2t_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= g2t_pkg::GRID_WIDTH_RST;
            r_grid_height <= g2t_pkg::GRID_HEIGHT_RST;
            r_plane_count <= g2t_pkg::PLANE_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                g2t_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[10:0];
                g2t_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[15:0];
                g2t_pkg::REG_PLANE_COUNT: r_plane_count <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            g2t_pkg::REG_GRID_WIDTH:  prdata = {21'd0, r_grid_width};
            g2t_pkg::REG_GRID_HEIGHT: prdata = {16'd0, r_grid_height};
            g2t_pkg::REG_PLANE_COUNT: prdata = {30'd0, r_plane_count};
            default:                  prdata = '0;
        endcase
    end

    logic three;
    assign three = (r_plane_count == g2t_pkg::PLANES_THREE);

    // effective sizes: width clamped to 1..MAX_WIDTH, height zero acts as 1
    logic [WE-1:0] gw_ext, eff_w;
    logic [16:0]   eff_h;
    assign gw_ext = WE'(r_grid_width);
    always_comb begin
        if (gw_ext == '0) begin
            eff_w = WE'(1);
        end else if (gw_ext > WE'(MAX_WIDTH)) begin
            eff_w = WE'(MAX_WIDTH);
        end else begin
            eff_w = gw_ext;
        end
    end
    assign eff_h = (r_grid_height == 16'd0) ? 17'd1 : {1'b0, r_grid_height};

    // ---------------- handshake control ----------------
    logic r_s1_valid, r_s1_emit, r_phase;
    logic r_out_valid, r_out_last;
    logic out_load_ok, load_a, load_b, s1_retire, in_accept;

    assign out_load_ok = !r_out_valid || i_out_ready;
    assign load_a      = r_s1_valid && r_s1_emit && !r_phase && out_load_ok;
    assign load_b      = r_s1_valid && r_s1_emit && r_phase && out_load_ok;
    assign s1_retire   = r_s1_valid && (!r_s1_emit || load_b);
    assign o_in_ready  = !r_s1_valid || s1_retire;
    assign in_accept   = i_in_valid && o_in_ready;

    // ---------------- grid counters ----------------
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [CW-1:0] n_col;
    logic [15:0]   n_row;
    logic          col_wrap;

    assign col_wrap = (WE'(r_col) + WE'(1)) >= eff_w;
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = (({1'b0, r_row} + 17'd1) >= eff_h) ? 16'd0 : r_row + 16'd1;
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- line store: read old, write current ----------------
    t_plane        cur_p2;
    logic [RAM_W-1:0] ram_wdata, ram_rdata;

    assign cur_p2    = three ? i_vertex_plane2 : '0;
    assign ram_wdata = {cur_p2, i_vertex_plane1, i_vertex_plane0};

    g2t_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (r_col),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // ---------------- quad stage ----------------
    t_vtx r_s1_cur, r_left, r_ul, ur;

    assign ur[0] = ram_rdata[PLANE_BITS-1:0];
    assign ur[1] = ram_rdata[2*PLANE_BITS-1:PLANE_BITS];
    assign ur[2] = ram_rdata[3*PLANE_BITS-1:2*PLANE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_phase    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_emit  <= (r_row != 16'd0) && (r_col != '0);
            end else if (s1_retire) begin
                r_s1_valid <= 1'b0;
            end
            if (load_a) begin
                r_phase <= 1'b1;
            end else if (load_b) begin
                r_phase <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cur[0] <= i_vertex_plane0;
            r_s1_cur[1] <= i_vertex_plane1;
            r_s1_cur[2] <= cur_p2;
        end
    end

    // left and upper-left vertices follow each retiring item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '{default: '0};
            r_ul   <= '{default: '0};
        end else if (s1_retire) begin
            r_left <= r_s1_cur;
            r_ul   <= ur;
        end
    end

    // ---------------- output register ----------------
    t_vtx r_out_c0, r_out_c1, r_out_c2;
    t_vtx tri_c0, tri_c1;

    // first triangle: UL, UR, L; second: UR, cur, L
    always_comb begin
        if (r_phase) begin
            tri_c0 = ur;
            tri_c1 = r_s1_cur;
        end else begin
            tri_c0 = r_ul;
            tri_c1 = ur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_a || load_b) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a || load_b) begin
            r_out_c0   <= tri_c0;
            r_out_c1   <= tri_c1;
            r_out_c2   <= r_left;
            r_out_last <= r_phase;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_last_of_pair   = r_out_last;
    assign o_corner0_plane0 = r_out_c0[0];
    assign o_corner0_plane1 = r_out_c0[1];
    assign o_corner0_plane2 = three ? r_out_c0[2] : '0;
    assign o_corner1_plane0 = r_out_c1[0];
    assign o_corner1_plane1 = r_out_c1[1];
    assign o_corner1_plane2 = three ? r_out_c1[2] : '0;
    assign o_corner2_plane0 = r_out_c2[0];
    assign o_corner2_plane1 = r_out_c2[1];
    assign o_corner2_plane2 = three ? r_out_c2[2] : '0;

    // ---------------- assertions ----------------
    // second-triangle phase only exists with an item in the quad stage
    `G2T_ASSERT_NOW(a_phase_has_item, r_phase, r_s1_valid)
    // a first triangle on the output means its partner is still pending
    `G2T_ASSERT_NOW(a_first_pending, r_out_valid && !r_out_last, r_phase)
    // taking a first triangle brings up the second one in the next cycle
    `G2T_ASSERT_NEXT(a_pair_follows, r_out_valid && i_out_ready && !r_out_last,
                     r_out_valid && r_out_last)

endmodule

`default_nettype wire
